// ===== hw/rtl/dbu_pkg.sv =====
// Shared types, register indexes and base tables for the DNA base unpacker.
`default_nettype none

package dbu_pkg;

   // Configuration register indexes.
   localparam logic CSR_TOTAL_BASES  = 1'b0;
   localparam logic CSR_TERNARY_MODE = 1'b1;

   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [7:0]  ESC_THRESHOLD = 8'd243;

   // Multiply-shift pair that gives floor(v / 3) for any v below 512.
   localparam logic [7:0] DIV3_MUL   = 8'd171;
   localparam int unsigned DIV3_SHIFT = 9;

   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_T = 8'h54;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TRUNC_ESC = 2'd1,
      STATUS_MISMATCH  = 2'd2
   } status_type;

   typedef enum logic {
      KIND_QUAD = 1'b0,
      KIND_TRI  = 1'b1
   } kind_type;

   // One classified byte: the work the back end has to carry out.
   typedef struct packed {
      kind_type   kind;
      logic [9:0] data;       // packed codes, lowest base in the low bits
      logic [2:0] n_items;    // result words to send, 1 to 5
      logic       has_bases;  // zero for a status-only word
      status_type status;     // placed on the final word only
   } desc_type;

   // Maps a 2-bit code to its ASCII base for either packing.
   function automatic logic [7:0] base_char_of(kind_type kind, logic [1:0] code);
      logic [7:0] ch;
      ch = CHAR_A;
      if (kind == KIND_QUAD) begin
         unique case (code)
            2'd0: ch = CHAR_A;
            2'd1: ch = CHAR_G;
            2'd2: ch = CHAR_C;
            2'd3: ch = CHAR_T;
            default: ch = CHAR_A;
         endcase
      end else begin
         unique case (code)
            2'd0: ch = CHAR_A;
            2'd1: ch = CHAR_G;
            2'd2: ch = CHAR_T;
            default: ch = CHAR_A;
         endcase
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dbu_if.sv =====
// Valid/ready channel interfaces for packed bytes in and decoded bases out.
`default_nettype none

interface dbu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       end_of_stream;

   modport source (output valid, output byte_value, output end_of_stream, input ready);
   modport sink   (input valid, input byte_value, input end_of_stream, output ready);
endinterface

interface dbu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] base_char;
   logic       base_valid;
   logic       last_of_item;
   logic [1:0] status;

   modport source (output valid, output base_char, output base_valid,
                   output last_of_item, output status, input ready);
   modport sink   (input valid, input base_char, input base_valid,
                   input last_of_item, input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dna_base_unpacker.sv =====
// Top level of the DNA base unpacker: registers, front end, queue and back end.
// A byte taken in moves through a queue slot and the back-end work register to the
// output register. Throughput: one result word per cycle while the receiver is
// ready, zero to five words per byte; the single output register sets that rate.
// Reset is synchronous and active high; it clears the base count, escape state,
// queue and output valid, and sets both configuration registers to zero.
`default_nettype none

module dna_base_unpacker
   import dbu_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   dbu_req_if.sink                    req_ch,
   dbu_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers. They are to be written only while the block is idle; the block does not enforce it.
   logic [31:0] total_bases_ff;
   logic        ternary_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_bases_ff  <= 32'd0;
         ternary_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TOTAL_BASES:  total_bases_ff  <= csr_wdata[31:0];
            CSR_TERNARY_MODE: ternary_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The front end takes a byte whenever the queue has room, so it goes on taking bytes
   // while the back end drains an earlier byte, and waits only when the queue is full.
   logic     q_full, q_push, q_pop, q_head_valid;
   desc_type q_push_desc, q_head_desc;
   logic     req_accept;

   assign req_ch.ready = !q_full;
   assign req_accept   = req_ch.valid && !q_full;

   dbu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .byte_value    (req_ch.byte_value),
      .end_of_stream (req_ch.end_of_stream),
      .total_bases   (total_bases_ff),
      .ternary_mode  (ternary_mode_ff),
      .push          (q_push),
      .push_desc     (q_push_desc)
   );

   // Bytes that give no result (ignored bytes and escape bytes not at the end of
   // the chunk) never enter the queue.
   dbu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_desc  (q_push_desc),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_desc  (q_head_desc)
   );

   // The back end loads the next queued byte in the same cycle that it sends the
   // final word of the current one, so words leave back to back.
   dbu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (q_head_valid),
      .head_desc      (q_head_desc),
      .pop            (q_pop),
      .out_valid      (rsp_ch.valid),
      .out_ready      (rsp_ch.ready),
      .out_char       (rsp_ch.base_char),
      .out_base_valid (rsp_ch.base_valid),
      .out_last       (rsp_ch.last_of_item),
      .out_status     (rsp_ch.status)
   );

`ifndef ASSERT_OFF
   // A status-only word is always the final word of its byte.
   a_status_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.base_valid) |-> rsp_ch.last_of_item)
      else $error("status-only word without last_of_item");

   // A nonzero status appears on the final word of a byte only.
   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status != STATUS_OK)) |-> rsp_ch.last_of_item)
      else $error("status placed before the final word of a byte");

   // A word without a base carries no character.
   a_empty_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.base_valid) |-> (rsp_ch.base_char == 8'd0))
      else $error("status-only word carries a character");

   // Nothing leaves in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/dbu_front.sv =====
// Front end: accepts packed bytes, tracks escapes and the base count, classifies work.
`default_nettype none

module dbu_front
   import dbu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [7:0]  byte_value,
   input  wire logic        end_of_stream,
   input  wire logic [31:0] total_bases,
   input  wire logic        ternary_mode,
   output      logic        push,
   output      desc_type    push_desc
);

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_WAIT_LOW,
      ESC_WAIT_HIGH
   } esc_phase_type;

   esc_phase_type esc_phase_ff, esc_phase_in;
   logic [7:0]    esc_low_ff, esc_low_in;
   logic [31:0]   done_ff, done_in;

   kind_type      kind;
   logic [9:0]    data;
   logic [2:0]    cand;
   logic [2:0]    n_emit;
   logic [31:0]   remaining;
   logic [31:0]   done_after;
   logic          below_total;
   status_type    status;

   always_comb begin
      esc_phase_in = esc_phase_ff;
      esc_low_in   = esc_low_ff;
      kind         = KIND_QUAD;
      data         = {2'b00, byte_value};
      cand         = 3'd0;
      below_total  = done_ff < total_bases;

      unique case (esc_phase_ff)
         ESC_WAIT_LOW: begin
            esc_low_in   = byte_value;
            esc_phase_in = ESC_WAIT_HIGH;
         end
         ESC_WAIT_HIGH: begin
            esc_phase_in = ESC_NONE;
            data         = {byte_value[1:0], esc_low_ff};
            cand         = 3'd5;
         end
         default: begin
            if (below_total) begin
               if (!ternary_mode) begin
                  cand = 3'd4;
               end else if (byte_value < ESC_THRESHOLD) begin
                  kind = KIND_TRI;
                  cand = 3'd5;
               end else begin
                  esc_phase_in = ESC_WAIT_LOW;
               end
            end
         end
      endcase

      // Bases stop as soon as the configured count is reached.
      remaining = below_total ? (total_bases - done_ff) : 32'd0;
      n_emit    = (remaining < {29'd0, cand}) ? remaining[2:0] : cand;
      done_after = done_ff + {29'd0, n_emit};

      if (!end_of_stream) begin
         status = STATUS_OK;
      end else if (esc_phase_in != ESC_NONE) begin
         status = STATUS_TRUNC_ESC;
      end else if (done_after != total_bases) begin
         status = STATUS_MISMATCH;
      end else begin
         status = STATUS_OK;
      end

      done_in = done_after;
      if (end_of_stream) begin
         done_in      = 32'd0;
         esc_phase_in = ESC_NONE;
         esc_low_in   = 8'd0;
      end

      push                = accept && ((n_emit != 3'd0) || end_of_stream);
      push_desc.kind      = kind;
      push_desc.data      = data;
      push_desc.has_bases = n_emit != 3'd0;
      push_desc.n_items   = (n_emit != 3'd0) ? n_emit : 3'd1;
      push_desc.status    = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_phase_ff <= ESC_NONE;
         esc_low_ff   <= 8'd0;
         done_ff      <= 32'd0;
      end else if (accept) begin
         esc_phase_ff <= esc_phase_in;
         esc_low_ff   <= esc_low_in;
         done_ff      <= done_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dbu_queue.sv =====
// Short first-in first-out queue of classified work between front and back.
`default_nettype none

module dbu_queue
   import dbu_pkg::*;
#(
   parameter int unsigned DEPTH = 2
)(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire desc_type push_desc,
   output      logic     full,
   input  wire logic     pop,
   output      logic     head_valid,
   output      desc_type head_desc
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   desc_type         slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full       = count_ff == FULL_CNT;
   assign head_valid = count_ff != '0;
   assign head_desc  = slots_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dbu_back.sv =====
// Back end: turns one classified word of work into a series of result words.
`default_nettype none

module dbu_back
   import dbu_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     head_valid,
   input  wire desc_type head_desc,
   output      logic     pop,
   output      logic     out_valid,
   input  wire logic     out_ready,
   output      logic [7:0] out_char,
   output      logic     out_base_valid,
   output      logic     out_last,
   output      logic [1:0] out_status
);

   logic       busy_ff;
   desc_type   work_ff;
   logic [2:0] left_ff;
   logic       out_valid_ff;
   logic [7:0] out_char_ff;
   logic       out_base_valid_ff;
   logic       out_last_ff;
   logic [1:0] out_status_ff;

   logic       can_emit, last_emit;
   logic [1:0] code;
   logic [15:0] prod;
   logic [7:0] quot;
   logic [9:0] data_next;
   logic [7:0] char_in;

   assign can_emit  = busy_ff && (!out_valid_ff || out_ready);
   assign last_emit = can_emit && (left_ff == 3'd1);
   assign pop       = head_valid && (!busy_ff || last_emit);

   always_comb begin
      // One base per step: two low bits, or a base-3 remainder via multiply-shift.
      prod = work_ff.data[7:0] * DIV3_MUL;
      quot = 8'(prod >> DIV3_SHIFT);
      if (work_ff.kind == KIND_TRI) begin
         code      = 2'(work_ff.data[7:0] - 8'(quot * 2'd3));
         data_next = {2'b00, quot};
      end else begin
         code      = work_ff.data[1:0];
         data_next = {2'b00, work_ff.data[9:2]};
      end
      char_in = work_ff.has_bases ? base_char_of(work_ff.kind, code) : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            busy_ff <= 1'b1;
         end else if (last_emit) begin
            busy_ff <= 1'b0;
         end
         if (can_emit) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         work_ff <= head_desc;
         left_ff <= head_desc.n_items;
      end else if (can_emit) begin
         work_ff.data <= data_next;
         left_ff      <= left_ff - 3'd1;
      end
      if (can_emit) begin
         out_char_ff       <= char_in;
         out_base_valid_ff <= work_ff.has_bases;
         out_last_ff       <= left_ff == 3'd1;
         out_status_ff     <= (left_ff == 3'd1) ? work_ff.status : STATUS_OK;
      end
   end

   assign out_valid      = out_valid_ff;
   assign out_char       = out_char_ff;
   assign out_base_valid = out_base_valid_ff;
   assign out_last       = out_last_ff;
   assign out_status     = out_status_ff;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the DNA base unpacker: stimulus, prediction and result checks.
`timescale 1ns / 1ps

module tb_top;
   import dbu_pkg::*;

   // The run is ended with a failure if it is still going after this many cycles.
   localparam int unsigned CYCLE_LIMIT = 200000;

   // Cycles allowed after the last expected word before the block counts as idle.
   // A byte that gives no result only updates front-end state; it never enters the queue.
   localparam int unsigned SETTLE_CYCLES = 12;

   // Length of the long receiver hold-off that fills the block and stalls its input.
   localparam int unsigned LONG_HOLD_CYCLES = 90;

   // Least number of bytes queued by the random part before the stimulus stops.
   localparam int unsigned RANDOM_BYTES = 135;

   localparam logic [7:0] QUAD_CHAR [4] = '{CHAR_A, CHAR_G, CHAR_C, CHAR_T};
   localparam logic [7:0] TRI_CHAR  [3] = '{CHAR_A, CHAR_G, CHAR_T};

   typedef enum logic [1:0] {
      ESC_IDLE      = 2'd0,
      ESC_WAIT_LOW  = 2'd1,
      ESC_WAIT_HIGH = 2'd2
   } esc_state_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_stream;
   } packed_byte_type;

   typedef struct packed {
      logic [7:0] base_char;
      logic       base_valid;
      logic       last_of_item;
      status_type status;
   } base_word_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic                  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dbu_req_if req_ch ();
   dbu_rsp_if rsp_ch ();

   dna_base_unpacker dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Packed bytes waiting to be offered, and decoded words waiting to arrive.
   packed_byte_type pending_bytes [$];
   base_word_type   expected_bases [$];
   base_word_type   step_words [$];

   // Our own copy of the configuration and of the decoder state.
   logic [31:0]   total_cfg;
   logic          ternary_cfg;
   logic [31:0]   bases_done;
   esc_state_type esc_state;
   logic [7:0]    esc_low;

   int unsigned mismatches;
   int unsigned cycles;
   int unsigned random_bytes;
   int unsigned hold_requests;
   int unsigned holds_served;

   always #4 clock = ~clock;

   // Counts one mismatch and prints it; printing stops after the first few.
   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 20) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   // Appends one base to the words of the current byte unless the count is used up.
   function automatic void add_base(input logic [7:0] ch);
      base_word_type w;
      if (bases_done < total_cfg) begin
         w = '{base_char: ch, base_valid: 1'b1, last_of_item: 1'b0, status: STATUS_OK};
         step_words = {step_words, w};
         bases_done++;
      end
   endfunction

   // Works out the words that one accepted byte causes and queues them as expected.
   task automatic decode_byte(input logic [7:0] data_byte, input logic eos);
      logic [15:0]   word;
      int unsigned   v;
      status_type    st;
      base_word_type w;
      step_words.delete();
      if (esc_state == ESC_WAIT_LOW) begin
         esc_low   = data_byte;
         esc_state = ESC_WAIT_HIGH;
      end else if (esc_state == ESC_WAIT_HIGH) begin
         // Only the low ten bits of the escape word carry bases.
         word      = {data_byte, esc_low};
         esc_state = ESC_IDLE;
         for (int k = 0; k < 5; k++) add_base(QUAD_CHAR[word[2*k +: 2]]);
      end else if (bases_done < total_cfg) begin
         if (!ternary_cfg) begin
            for (int k = 0; k < 4; k++) add_base(QUAD_CHAR[data_byte[2*k +: 2]]);
         end else if (data_byte < ESC_THRESHOLD) begin
            v = data_byte;
            for (int k = 0; k < 5; k++) begin
               add_base(TRI_CHAR[v % 3]);
               v = v / 3;
            end
         end else begin
            esc_state = ESC_WAIT_LOW;
         end
      end

      if (eos) begin
         if (esc_state != ESC_IDLE) begin
            st = STATUS_TRUNC_ESC;
         end else if (bases_done != total_cfg) begin
            st = STATUS_MISMATCH;
         end else begin
            st = STATUS_OK;
         end
         // A closing byte with no bases still gives one status-only word.
         if (step_words.size() == 0) begin
            w = '{base_char: 8'h00, base_valid: 1'b0, last_of_item: 1'b0, status: STATUS_OK};
            step_words = {step_words, w};
         end
         step_words[step_words.size()-1].status = st;
         bases_done = '0;
         esc_state  = ESC_IDLE;
         esc_low    = '0;
      end

      if (step_words.size() != 0) begin
         step_words[step_words.size()-1].last_of_item = 1'b1;
      end
      foreach (step_words[i]) expected_bases = {expected_bases, step_words[i]};
   endtask

   task automatic queue_byte(input logic [7:0] data_byte, input logic eos);
      packed_byte_type p;
      p = '{byte_value: data_byte, end_of_stream: eos};
      pending_bytes = {pending_bytes, p};
   endtask

   // Writes both registers back to back; only called while the block is idle.
   task automatic set_config(input logic [31:0] total, input logic tern);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TOTAL_BASES;
      csr_wdata <= total;
      @(posedge clock);
      csr_index <= CSR_TERNARY_MODE;
      csr_wdata <= {{(CSR_DATA_W-1){1'b0}}, tern};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      total_cfg   = total;
      ternary_cfg = tern;
   endtask

   // Waits until every byte is taken and every expected word has arrived, then lets
   // the block settle so that bytes without results have left the pipeline too.
   // The check runs on the falling edge, when the driver and monitor have settled.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_bytes.size() != 0 || req_ch.valid || expected_bases.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random phase: a random setting, then one or two chunks. Most chunks are
   // well formed and sized around the base count; some end inside an escape word
   // or lose their closing flag, so that the chunk runs on into the next phase.
   task automatic run_random_phase();
      logic [31:0] total;
      logic        tern;
      logic        broken;
      logic        last;
      int          sel;
      int          len;
      int          cut;
      tern = 1'($urandom_range(0, 1));
      sel  = $urandom_range(0, 9);
      if (sel == 0) begin
         total = '1;
      end else if (sel == 1) begin
         total = $urandom();
      end else if (sel == 2) begin
         total = '0;
      end else begin
         total = $urandom_range(1, 30);
      end
      set_config(total, tern);
      repeat ($urandom_range(1, 2)) begin
         if (total <= 30) begin
            len = total / (tern ? 5 : 4) + $urandom_range(0, 2);
         end else begin
            len = $urandom_range(2, 8);
         end
         if (len < 1) len = 1;
         if (len > 10) len = 10;
         broken = ($urandom_range(0, 5) == 0);
         cut    = $urandom_range(0, 2);
         for (int i = 0; i < len; i++) begin
            last = (i == len - 1);
            if (tern && $urandom_range(0, 4) == 0) begin
               // Escape byte followed by the two bytes of its word.
               queue_byte(8'($urandom_range(243, 255)), last && broken && cut == 0);
               queue_byte(8'($urandom()), last && broken && cut == 1);
               queue_byte(8'($urandom()), last && !broken);
               random_bytes += 3;
            end else begin
               queue_byte(tern ? 8'($urandom_range(0, 242)) : 8'($urandom_range(0, 255)),
                          last && (!broken || cut != 2));
               random_bytes++;
            end
         end
      end
   endtask

   // Sender: offers bytes from the pending queue in bursts of random length with
   // random gaps; some gaps are zero so that long unbroken streams occur too.
   int burst_left;
   int gap_left;
   packed_byte_type next_byte;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = $urandom_range(1, 16);
         gap_left   = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            next_byte = pending_bytes.pop_front();
            req_ch.valid         <= 1'b1;
            req_ch.byte_value    <= next_byte.byte_value;
            req_ch.end_of_stream <= next_byte.end_of_stream;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: stalls with a rate picked anew at random intervals, and on
   // request holds ready low for a long stretch so the block backs up.
   int unsigned hold_left;
   int unsigned pattern_left;
   int unsigned stall_pct;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    = 0;
         pattern_left = 0;
         stall_pct    = 0;
      end else begin
         if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
               0: begin
                  stall_pct = 0;
               end
               1: begin
                  stall_pct = 30;
               end
               default: begin
                  stall_pct = 75;
               end
            endcase
         end else begin
            pattern_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Monitor: predicts on each accepted byte and checks each accepted word
   // against the oldest expectation.
   base_word_type want;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            decode_byte(req_ch.byte_value, req_ch.end_of_stream);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_bases.size() == 0) begin
               report_mismatch($sformatf("word with nothing expected: char %h valid %b",
                                         rsp_ch.base_char, rsp_ch.base_valid));
            end else begin
               want = expected_bases.pop_front();
               if (rsp_ch.base_char !== want.base_char) begin
                  report_mismatch($sformatf("base_char %h, expected %h",
                                            rsp_ch.base_char, want.base_char));
               end
               if (rsp_ch.base_valid !== want.base_valid) begin
                  report_mismatch($sformatf("base_valid %b, expected %b",
                                            rsp_ch.base_valid, want.base_valid));
               end
               if (rsp_ch.last_of_item !== want.last_of_item) begin
                  report_mismatch($sformatf("last_of_item %b, expected %b",
                                            rsp_ch.last_of_item, want.last_of_item));
               end
               if (rsp_ch.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_ch.status, want.status));
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d words still expected", expected_bases.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = CSR_TOTAL_BASES;
      csr_wdata            = '0;
      req_ch.valid         = 1'b0;
      req_ch.byte_value    = '0;
      req_ch.end_of_stream = 1'b0;
      rsp_ch.ready         = 1'b0;
      total_cfg            = '0;
      ternary_cfg          = 1'b0;
      bases_done           = '0;
      esc_state            = ESC_IDLE;
      esc_low              = '0;
      mismatches           = 0;
      cycles               = 0;
      random_bytes         = 0;
      hold_requests        = 0;
      holds_served         = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Binary packing with the extreme bytes; the third byte arrives after the
      // count is met, so it is ignored and only closes the chunk.
      set_config(32'd8, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hE4, 1'b1);
      wait_drained();

      // The count runs out in the middle of a byte, which also closes the chunk.
      set_config(32'd3, 1'b0);
      queue_byte(8'h1B, 1'b1);
      wait_drained();

      // Ternary extremes, then an escape whose word has all unused bits set and
      // whose high byte closes the chunk.
      set_config(32'd15, 1'b1);
      queue_byte(8'd0, 1'b0);
      queue_byte(8'd242, 1'b0);
      queue_byte(8'd243, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b1);
      wait_drained();

      // The chunk ends on the escape byte itself: truncated escape.
      set_config(32'd10, 1'b1);
      queue_byte(8'd200, 1'b0);
      queue_byte(8'd255, 1'b1);
      wait_drained();

      // An escape is left pending across a change to binary mode and a count
      // below what is already done; its word is still consumed, gives no bases,
      // and the chunk closes with a mismatch.
      set_config(32'd20, 1'b1);
      queue_byte(8'd100, 1'b0);
      queue_byte(8'd250, 1'b0);
      wait_drained();
      set_config(32'd2, 1'b0);
      queue_byte(8'h34, 1'b0);
      queue_byte(8'h12, 1'b1);
      wait_drained();

      // Largest count: the chunk always closes short of it.
      set_config(32'hFFFF_FFFF, 1'b0);
      queue_byte(8'hA5, 1'b0);
      queue_byte(8'h5A, 1'b0);
      queue_byte(8'h3C, 1'b1);
      wait_drained();

      // Zero count in ternary mode: the escape byte is ignored like any other.
      set_config(32'd0, 1'b1);
      queue_byte(8'd250, 1'b0);
      queue_byte(8'd7, 1'b1);
      wait_drained();

      // Random part. One phase streams a long chunk into a receiver that holds
      // off for a long time, so the block fills and pushes back on its input.
      for (int phase = 0; random_bytes < RANDOM_BYTES; phase++) begin
         if (phase == 2) begin
            set_config(32'hFFFF_FFFF, 1'b0);
            hold_requests++;
            for (int i = 0; i < 16; i++) begin
               queue_byte(8'($urandom()), i == 15);
            end
            random_bytes += 16;
         end else begin
            run_random_phase();
         end
         wait_drained();
      end

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/dbu_pkg.sv
hw/rtl/dbu_if.sv
hw/rtl/dbu_front.sv
hw/rtl/dbu_queue.sv
hw/rtl/dbu_back.sv
hw/rtl/dna_base_unpacker.sv
dv/tb_top.sv
